/* hdl/rsenc_pkg.sv */
`timescale 1ns / 1ps

package rsenc_pkg;

  // Largest supported parity length (degree of the generator polynomial).
  localparam int MAX_PARITY = 32;
  // Width of the configuration field as it appears on the port.
  localparam int CFG_W      = 6;
  // Width that holds any effective length from 1 up to MAX_PARITY.
  localparam int LEN_W      = $clog2(MAX_PARITY + 1);
  localparam int LEN_RESET  = 10;

  // Field polynomial x^8 + x^4 + x^3 + x^2 + 1: low byte and top bit.
  localparam logic [7:0] FIELD_LOW = 8'h1D;
  localparam logic [7:0] FIELD_TOP = 8'h80;
  localparam logic [7:0] ALPHA     = 8'h02;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] parity_byte;
    logic       parity_last;
  } out_word_t;

  // Generator coefficients, index 0 is the leading (monic) coefficient.
  typedef logic [MAX_PARITY:0][7:0] gen_vec_t;
  // Remainder and parity shift line, index 0 is the highest-order byte.
  typedef logic [MAX_PARITY-1:0][7:0] byte_vec_t;

  typedef struct packed {
    logic             busy;
    logic [LEN_W-1:0] len;
  } gen_status_t;

  // GF(256) multiply, MSB-first shift and add.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 7; i >= 0; i--) begin
      if ((acc & FIELD_TOP) != 8'h00) begin
        acc = {acc[6:0], 1'b0} ^ FIELD_LOW;
      end else begin
        acc = {acc[6:0], 1'b0};
      end
      if (b[i]) begin
        acc = acc ^ a;
      end
    end
    return acc;
  endfunction

  // Multiply by alpha.
  function automatic logic [7:0] gf_xtime(input logic [7:0] a);
    logic [7:0] res;
    res = {a[6:0], 1'b0} ^ (((a & FIELD_TOP) != 8'h00) ? FIELD_LOW : 8'h00);
    return res;
  endfunction

endpackage

/* hdl/rsenc_gen.sv */
`timescale 1ns / 1ps

// Builds the generator polynomial one root per cycle: each step multiplies
// the current polynomial by (x + alpha^i).
module rsenc_gen
  import rsenc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output gen_vec_t         gen_coef,
  output gen_status_t      status
);

  gen_vec_t         gen_r, gen_nxt;
  logic [7:0]       root_r, root_nxt;
  logic [LEN_W-1:0] step_r, step_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] len_clamped;
  gen_vec_t         gen_init;
  logic             busy;

  always_comb begin
    gen_init    = '0;
    gen_init[0] = 8'h01;
    gen_init[1] = 8'h01;
  end

  // Zero means one, anything above the maximum saturates.
  always_comb begin
    if (cfg_wdata == '0) begin
      len_clamped = LEN_W'(1);
    end else if (int'(cfg_wdata) > MAX_PARITY) begin
      len_clamped = LEN_W'(MAX_PARITY);
    end else begin
      len_clamped = LEN_W'(cfg_wdata);
    end
  end

  assign busy = (step_r < len_r);

  always_comb begin
    gen_nxt  = gen_r;
    root_nxt = root_r;
    step_nxt = step_r;
    len_nxt  = len_r;
    if (cfg_we) begin
      gen_nxt  = gen_init;
      root_nxt = ALPHA;
      step_nxt = LEN_W'(1);
      len_nxt  = len_clamped;
    end else if (busy) begin
      // Coefficients above the current degree are zero, so one uniform
      // update covers the whole vector.
      for (int k = 1; k <= MAX_PARITY; k++) begin
        gen_nxt[k] = gen_r[k] ^ gf_mul(gen_r[k-1], root_r);
      end
      root_nxt = gf_xtime(root_r);
      step_nxt = step_r + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r  <= gen_init;
      root_r <= ALPHA;
      step_r <= LEN_W'(1);
      len_r  <= LEN_W'(LEN_RESET);
    end else begin
      gen_r  <= gen_nxt;
      root_r <= root_nxt;
      step_r <= step_nxt;
      len_r  <= len_nxt;
    end
  end

  assign gen_coef    = gen_r;
  assign status.busy = busy;
  assign status.len  = len_r;

endmodule

/* hdl/reed_solomon_ecc_encoder.sv */
// Channel  Ports                              Carries
// -------  ---------------------------------  ---------------------------------
// in       in_valid, in_ready, in_data        one message byte and last flag
// out      out_valid, out_ready, out_data     one parity byte and final flag
// cfg      cfg_we, cfg_wdata                  parity length, written at once
//
// An input word is taken every cycle that in_ready is high; it is registered
// in the input stage and then updates the whole remainder in a single pass.
// A block's parity words leave one per cycle while out_ready is high, from a
// shift line, so the next block streams in meanwhile; a last word stalls only
// if parity is still out. After reset or a length write, in_ready is low while
// the generator builds. Synchronous active-low reset.
`timescale 1ns / 1ps

module reed_solomon_ecc_encoder
  import rsenc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  gen_vec_t    gen_coef;
  gen_status_t gen_status;

  // Generator builder: holds the coefficients and the effective length.
  rsenc_gen u_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .gen_coef  (gen_coef),
    .status    (gen_status)
  );

  // Input stage.
  logic      stage_valid_r, stage_valid_nxt;
  in_word_t  stage_r, stage_nxt;

  // Remainder, and the shift line that carries a finished block's parity.
  byte_vec_t        rem_r, rem_nxt;
  byte_vec_t        shift_r, shift_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;

  logic                  out_fire;
  logic                  in_fire;
  logic                  shift_free;
  logic                  stage_go;
  logic [7:0]            fb;
  logic [MAX_PARITY:0][7:0] rem_ext;
  byte_vec_t             rem_step;

  assign out_valid            = (cnt_r != '0);
  assign out_data.parity_byte = shift_r[0];
  assign out_data.parity_last = (cnt_r == LEN_W'(1));
  assign out_fire             = out_valid && out_ready;

  // The shift line can take a new block when empty or once its final word is leaving.
  assign shift_free = (cnt_r == '0) || ((cnt_r == LEN_W'(1)) && out_fire);
  assign stage_go   = stage_valid_r && (!stage_r.last_byte || shift_free);
  assign in_ready   = !gen_status.busy && (!stage_valid_r || stage_go);
  assign in_fire    = in_valid && in_ready;

  // One LFSR step. Bytes above the current length are always zero, as are
  // the generator coefficients above its degree, so the step needs no
  // knowledge of the length.
  assign fb = stage_r.data_byte ^ rem_r[0];

  always_comb begin
    rem_ext             = '0;
    rem_ext[MAX_PARITY-1:0] = rem_r;
    for (int j = 0; j < MAX_PARITY; j++) begin
      rem_step[j] = rem_ext[j+1] ^ gf_mul(gen_coef[j+1], fb);
    end
  end

  always_comb begin
    stage_nxt       = stage_r;
    stage_valid_nxt = stage_valid_r;
    if (in_fire) begin
      stage_nxt       = in_data;
      stage_valid_nxt = 1'b1;
    end else if (stage_go) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    rem_nxt = rem_r;
    if (cfg_we) begin
      // A length write discards any partial block.
      rem_nxt = '0;
    end else if (stage_go) begin
      rem_nxt = stage_r.last_byte ? byte_vec_t'('0) : rem_step;
    end
  end

  always_comb begin
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    if (stage_go && stage_r.last_byte) begin
      shift_nxt = rem_step;
      cnt_nxt   = gen_status.len;
    end else if (out_fire) begin
      for (int j = 0; j < MAX_PARITY - 1; j++) begin
        shift_nxt[j] = shift_r[j+1];
      end
      shift_nxt[MAX_PARITY-1] = 8'h00;
      cnt_nxt = cnt_r - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      rem_r         <= '0;
      cnt_r         <= '0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      rem_r         <= rem_nxt;
      cnt_r         <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
    shift_r <= shift_nxt;
  end

  // A block's parity count is loaded with the length in force at its end.
  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_go && stage_r.last_byte) |=> (cnt_r == $past(gen_status.len)))
    else $error("parity count not loaded with the block length");

  // After the final parity word leaves, the output is empty unless the
  // next block was loaded at the same edge.
  a_block_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_data.parity_last) |=>
      (!out_valid || $past(stage_go && stage_r.last_byte)))
    else $error("parity words continue past the final word");

  // A held last word waits only on parity still being sent.
  a_last_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_valid_r && stage_r.last_byte && !stage_go) |-> out_valid)
    else $error("last word stalled with the output idle");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import rsenc_pkg::*;

  // Expected parity for the encoder. It keeps its own copy of the generator
  // polynomial and of the running remainder. It queues one word for every
  // parity byte that a block's last message byte releases.
  class parity_scoreboard;
    logic [7:0]  gen_coef [MAX_PARITY+1];
    logic [7:0]  rem [MAX_PARITY];
    int unsigned len_eff;
    int unsigned error_count;
    out_word_t   expected_q[$];

    function new();
      error_count = 0;
      set_length(CFG_W'(LEN_RESET));
    endfunction

    // GF(256) product, LSB-first shift and add over 0x11D.
    function logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] p;
      x = a;
      y = b;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
        if (y[0]) p = p ^ x;
        x = {x[6:0], 1'b0} ^ (x[7] ? FIELD_LOW : 8'h00);
        y = y >> 1;
      end
      return p;
    endfunction

    // A length write rebuilds g(x) = prod (x + alpha^i) and drops any partial block.
    function void set_length(logic [CFG_W-1:0] value);
      logic [7:0] root;
      if (value == 0) len_eff = 1;
      else if (value > MAX_PARITY) len_eff = MAX_PARITY;
      else len_eff = value;
      foreach (gen_coef[k]) gen_coef[k] = 8'h00;
      foreach (rem[k]) rem[k] = 8'h00;
      gen_coef[0] = 8'h01;
      gen_coef[1] = 8'h01;
      root = 8'h01;
      for (int i = 1; i < len_eff; i++) begin
        root = gmul(root, ALPHA);
        gen_coef[i+1] = gmul(gen_coef[i], root);
        for (int k = i; k >= 1; k--) gen_coef[k] = gen_coef[k] ^ gmul(gen_coef[k-1], root);
      end
    endfunction

    function void note_word(in_word_t w);
      logic [7:0] fb;
      out_word_t  e;
      fb = w.data_byte ^ rem[0];
      for (int j = 0; j + 1 < len_eff; j++) rem[j] = rem[j+1] ^ gmul(gen_coef[j+1], fb);
      rem[len_eff-1] = gmul(gen_coef[len_eff], fb);
      if (w.last_byte) begin
        for (int j = 0; j < len_eff; j++) begin
          e.parity_byte = rem[j];
          e.parity_last = (j + 1 == len_eff);
          expected_q.push_back(e);
        end
        foreach (rem[k]) rem[k] = 8'h00;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: parity word %02h last %0b with nothing expected", $time,
                 got.parity_byte, got.parity_last);
        error_count++;
        return;
      end
      e = expected_q.pop_front();
      if (got.parity_byte !== e.parity_byte) begin
        $display("%0t: parity byte mismatch, expected %02h got %02h", $time,
                 e.parity_byte, got.parity_byte);
        error_count++;
      end
      if (got.parity_last !== e.parity_last) begin
        $display("%0t: parity last flag mismatch, expected %0b got %0b", $time,
                 e.parity_last, got.parity_last);
        error_count++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_word_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_word_t        out_data;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  parity_scoreboard parity_sb;

  // Sender and receiver pacing. Each side draws a pause per word. Every 24
  // words it may switch into a calm stretch with no pauses at all.
  bit          tx_calm;
  bit          rx_calm;
  int unsigned tx_count;
  int unsigned rx_count;
  int unsigned words_sent;
  // Set by the stimulus to make the receiver hold off once for a long stretch.
  bit          hold_req;

  reed_solomon_ecc_encoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned draw_pause(input bit calm);
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // Present one message word and hold it until the encoder takes it. The
  // task returns in the time step of acceptance with in_valid still high. A
  // following call may keep it high for a back-to-back word. Any other caller
  // must lower it.
  task automatic send_word(input logic [7:0] data, input logic last);
    int unsigned pause;
    in_word_t    w;
    if (tx_count % 24 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    tx_count++;
    pause = draw_pause(tx_calm);
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    w.data_byte = data;
    w.last_byte = last;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    parity_sb.note_word(w);
    words_sent++;
  endtask

  task automatic send_block(input int unsigned nbytes);
    for (int unsigned i = 1; i <= nbytes; i++) begin
      send_word(8'($urandom_range(0, 255)), i == nbytes);
    end
  endtask

  // The encoder is idle once all parity has come out. A trailing non-last
  // word may still sit in the input stage, so wait on past the last parity word.
  task automatic wait_idle();
    while (parity_sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // A length write while idle. The encoder then rebuilds its generator with
  // in_ready low. The sender simply waits on the handshake.
  task automatic write_length(input logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    wait_idle();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    parity_sb.set_length(value);
  endtask

  // Mostly short parity lengths keep blocks quick. The extremes and the
  // out-of-range codes (zero, above the maximum) still come up often.
  function automatic logic [CFG_W-1:0] pick_length();
    case ($urandom_range(0, 9))
      0: return 6'd0;
      1: return 6'(MAX_PARITY);
      2: return 6'($urandom_range(MAX_PARITY + 1, 63));
      3, 4: return 6'($urandom_range(0, 63));
      default: return 6'($urandom_range(1, 12));
    endcase
  endfunction

  // Receiver. It stalls out_ready for a drawn number of cycles and then
  // waits for one parity word. At most one assignment to out_ready happens
  // per time step, so back-to-back acceptance keeps it high.
  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_count % 24 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      rx_count++;
      if (hold_req) begin
        hold_req = 1'b0;
        stall = 300;
      end else begin
        stall = draw_pause(rx_calm);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Every accepted parity word is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      parity_sb.check_word(out_data);
    end
  end

  // The watchdog sits far above the slowest legal run. That run has every
  // word closing a 32-byte block and every parity word stalled by the longest pause.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned pick;
    parity_sb  = new();
    tx_count   = 0;
    rx_count   = 0;
    words_sent = 0;
    hold_req   = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset length of ten. An all-zero block gives zero
    // parity. Then come data extremes, and a block whose first feedback byte
    // is exactly one.
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h55, 1'b1);
    send_word(8'h01, 1'b1);
    send_word(8'hFE, 1'b0);
    send_word(8'h7F, 1'b1);

    // A length of zero acts as one, so each block yields a single flagged word.
    write_length(6'd0);
    send_word(8'hFF, 1'b1);
    send_word(8'h01, 1'b0);
    send_word(8'h02, 1'b1);

    // All ones on the register saturates to the largest length.
    write_length(6'h3F);
    send_word(8'hAA, 1'b0);
    send_word(8'h55, 1'b1);
    write_length(6'(MAX_PARITY));
    send_word(8'hFF, 1'b1);
    write_length(6'd1);
    send_word(8'h80, 1'b1);

    // A write in the middle of a block throws the partial remainder away.
    write_length(6'd5);
    send_word(8'h03, 1'b0);
    send_word(8'h09, 1'b0);
    write_length(6'(MAX_PARITY + 1));
    send_word(8'hC3, 1'b1);

    // Back pressure. The receiver holds off once while short blocks keep
    // coming. The parity line fills and the encoder must stall its input.
    write_length(6'd4);
    hold_req = 1'b1;
    repeat (8) send_block(2);

    // Random part. Most of it is whole blocks with random content. Now and
    // then the length changes between blocks, or a block is cut short by a
    // length write.
    while (words_sent < 270) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        write_length(pick_length());
      end else if (pick == 1) begin
        repeat ($urandom_range(1, 6)) send_word(8'($urandom_range(0, 255)), 1'b0);
        write_length(pick_length());
      end else if (pick == 2) begin
        send_block($urandom_range(9, 40));
      end else begin
        send_block($urandom_range(1, 8));
      end
    end

    in_valid <= 1'b0;
    wait_idle();
    if (parity_sb.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
